### hdl/dsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsa_pkg
// Types, register indexes and decode helpers for the dual encoder setpoint
// adjuster.
// ----------------------------------------------------------------------------
package dsa_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 9;

   localparam logic [CSR_INDEX_W-1:0] CSR_SETUP_MODE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE_LIMIT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_VOLTAGE_MAX    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CURRENT_MAX    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_MAX       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_AMPLITUDE = 3'd5;

   localparam logic [3:0] DEBOUNCE_LIMIT_RST = 4'd10;
   localparam logic [7:0] VOLTAGE_MAX_RST    = 8'd240;
   localparam logic [8:0] CURRENT_MAX_RST    = 9'd300;
   localparam logic [6:0] GAIN_MAX_RST       = 7'd100;
   localparam logic [7:0] STEP_AMPLITUDE_RST = 8'd120;

   localparam logic [1:0] CURSOR_P = 2'd0;
   localparam logic [1:0] CURSOR_I = 2'd1;
   localparam logic [1:0] CURSOR_D = 2'd2;

   typedef enum logic [1:0] {
      DIR_NONE  = 2'd0,
      DIR_LEFT  = 2'd1,
      DIR_RIGHT = 2'd2
   } dsa_dir_type;

   typedef struct packed {
      logic enc0_a;
      logic enc0_b;
      logic enc0_button;
      logic enc1_a;
      logic enc1_b;
      logic enc1_button;
   } dsa_req_type;

   typedef struct packed {
      logic [7:0] voltage_setpoint;
      logic [8:0] current_setpoint;
      logic [6:0] gain_p;
      logic [6:0] gain_i;
      logic [6:0] gain_d;
      logic [1:0] gain_cursor;
      logic [7:0] step_level;
      logic       button0_pressed;
      logic       button1_pressed;
   } dsa_rsp_type;

   typedef struct packed {
      dsa_dir_type dir;
      logic        click;
      logic        settled;
   } dsa_enc_status_type;

   // Old-to-new A/B: 00->01, 11->10 right; 01->00, 10->11 left; else no move.
   function automatic dsa_dir_type dsa_decode(logic [1:0] old_ab, logic [1:0] new_ab);
      dsa_dir_type dir;
      dir = DIR_NONE;
      case ({old_ab, new_ab})
         4'b0001, 4'b1110: dir = DIR_RIGHT;
         4'b0100, 4'b1011: dir = DIR_LEFT;
         default:          dir = DIR_NONE;
      endcase
      return dir;
   endfunction

   // Saturating single step, floor 0 and ceiling top.
   function automatic logic [8:0] dsa_sat_move(logic [8:0] value, logic [8:0] top,
                                               dsa_dir_type dir);
      logic [8:0] res;
      res = value;
      if (dir == DIR_LEFT && value != 9'd0) begin
         res = value - 9'd1;
      end else if (dir == DIR_RIGHT && value < top) begin
         res = value + 9'd1;
      end
      return res;
   endfunction

endpackage

### hdl/dual_encoder_setpoint_adjuster.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_encoder_setpoint_adjuster
// Two rotary encoders with push buttons adjust voltage and current
// setpoints, or three tuning gains and a step level in setup mode.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one sample tick of both encoders (A, B, active-low button)
//   per word. rsp_* returns one word per tick with all setpoints, gains,
//   cursor, step level and debounced button states after that tick.
//   csr_* writes the six control registers; write only while idle.
// Timing:
//   A word is registered in the input register; the decode, debounce and
//   saturating updates run in one pass from there into the result
//   register. One word per cycle is sustained while rsp_ready is high;
//   the input register and result register each hold one word.
// Reset:
//   Clears the control, handshake and encoder state and loads the default
//   limits. The first tick after reset only captures A/B levels.
// Stall:
//   When rsp_ready is low the result holds, the input register fills, and
//   req_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module dual_encoder_setpoint_adjuster
   import dsa_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  dsa_req_type            req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output dsa_rsp_type            rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // control registers
   logic       setup_mode_ff;
   logic [3:0] debounce_limit_ff;
   logic [7:0] voltage_max_ff;
   logic [8:0] current_max_ff;
   logic [6:0] gain_max_ff;
   logic [7:0] step_amplitude_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         setup_mode_ff     <= 1'b0;
         debounce_limit_ff <= DEBOUNCE_LIMIT_RST;
         voltage_max_ff    <= VOLTAGE_MAX_RST;
         current_max_ff    <= CURRENT_MAX_RST;
         gain_max_ff       <= GAIN_MAX_RST;
         step_amplitude_ff <= STEP_AMPLITUDE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SETUP_MODE:     setup_mode_ff     <= csr_wdata[0];
            CSR_DEBOUNCE_LIMIT: debounce_limit_ff <= csr_wdata[3:0];
            CSR_VOLTAGE_MAX:    voltage_max_ff    <= csr_wdata[7:0];
            CSR_CURRENT_MAX:    current_max_ff    <= csr_wdata[8:0];
            CSR_GAIN_MAX:       gain_max_ff       <= csr_wdata[6:0];
            CSR_STEP_AMPLITUDE: step_amplitude_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // input register and result register handshake
   logic        in_valid_ff;
   dsa_req_type in_data_ff;
   logic        rsp_valid_ff;
   dsa_rsp_type rsp_data_ff, rsp_data_in;
   logic        advance;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         rsp_valid_ff <= advance || (rsp_valid_ff && !rsp_ready);
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // encoder channels
   logic               primed_ff;
   logic               prime_en, update_en;
   dsa_enc_status_type st0, st1;

   assign prime_en  = advance && !primed_ff;
   assign update_en = advance && primed_ff;

   dsa_enc_channel u_enc0 (
      .clock          (clock),
      .reset          (reset),
      .prime_en       (prime_en),
      .update_en      (update_en),
      .ab             ({in_data_ff.enc0_a, in_data_ff.enc0_b}),
      .button         (in_data_ff.enc0_button),
      .debounce_limit (debounce_limit_ff),
      .status         (st0)
   );

   dsa_enc_channel u_enc1 (
      .clock          (clock),
      .reset          (reset),
      .prime_en       (prime_en),
      .update_en      (update_en),
      .ab             ({in_data_ff.enc1_a, in_data_ff.enc1_b}),
      .button         (in_data_ff.enc1_button),
      .debounce_limit (debounce_limit_ff),
      .status         (st1)
   );

   // setpoint, gain and step state
   logic [1:0] cursor_ff, cursor_in;
   logic [7:0] voltage_ff, voltage_in;
   logic [8:0] current_ff, current_in;
   logic [6:0] gain_p_ff, gain_p_in;
   logic [6:0] gain_i_ff, gain_i_in;
   logic [6:0] gain_d_ff, gain_d_in;
   logic [7:0] step_ff, step_in;
   logic [6:0] gain_sel;
   logic [8:0] volt_sat, curr_sat, gain_sat;

   always_comb begin
      cursor_in = cursor_ff;
      if (update_en && setup_mode_ff && st1.click) begin
         cursor_in = (cursor_ff == CURSOR_D) ? CURSOR_P : cursor_ff + 2'd1;
      end
   end

   always_comb begin
      case (cursor_in)
         CURSOR_P: gain_sel = gain_p_ff;
         CURSOR_I: gain_sel = gain_i_ff;
         default:  gain_sel = gain_d_ff;
      endcase
   end

   assign volt_sat = dsa_sat_move({1'b0, voltage_ff}, {1'b0, voltage_max_ff}, st0.dir);
   assign curr_sat = dsa_sat_move(current_ff, current_max_ff, st1.dir);
   assign gain_sat = dsa_sat_move({2'b00, gain_sel}, {2'b00, gain_max_ff}, st1.dir);

   always_comb begin
      voltage_in = voltage_ff;
      current_in = current_ff;
      gain_p_in  = gain_p_ff;
      gain_i_in  = gain_i_ff;
      gain_d_in  = gain_d_ff;
      step_in    = step_ff;
      if (update_en) begin
         if (setup_mode_ff) begin
            case (cursor_in)
               CURSOR_P: gain_p_in = gain_sat[6:0];
               CURSOR_I: gain_i_in = gain_sat[6:0];
               default:  gain_d_in = gain_sat[6:0];
            endcase
            step_in = st0.settled ? step_amplitude_ff : 8'd0;
         end else begin
            voltage_in = volt_sat[7:0];
            current_in = curr_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff  <= 1'b0;
         cursor_ff  <= CURSOR_P;
         voltage_ff <= 8'd0;
         current_ff <= 9'd0;
         gain_p_ff  <= 7'd0;
         gain_i_ff  <= 7'd0;
         gain_d_ff  <= 7'd0;
         step_ff    <= 8'd0;
      end else begin
         if (advance) begin
            primed_ff <= 1'b1;
         end
         cursor_ff  <= cursor_in;
         voltage_ff <= voltage_in;
         current_ff <= current_in;
         gain_p_ff  <= gain_p_in;
         gain_i_ff  <= gain_i_in;
         gain_d_ff  <= gain_d_in;
         step_ff    <= step_in;
      end
   end

   always_comb begin
      rsp_data_in.voltage_setpoint = voltage_in;
      rsp_data_in.current_setpoint = current_in;
      rsp_data_in.gain_p           = gain_p_in;
      rsp_data_in.gain_i           = gain_i_in;
      rsp_data_in.gain_d           = gain_d_in;
      rsp_data_in.gain_cursor      = cursor_in;
      rsp_data_in.step_level       = step_in;
      rsp_data_in.button0_pressed  = st0.settled;
      rsp_data_in.button1_pressed  = st1.settled;
   end

   // checks
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      cursor_ff != 2'd3)
      else $error("gain cursor out of range");

   a_advance_to_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced word did not reach the result register");

   a_step_only_setup: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$stable(step_ff) |-> $past(advance && setup_mode_ff))
      else $error("step level changed outside setup mode");

   a_voltage_only_normal: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$stable(voltage_ff) |-> $past(advance && !setup_mode_ff))
      else $error("voltage setpoint changed outside normal mode");

   a_gain_only_setup: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$stable({gain_p_ff, gain_i_ff, gain_d_ff})
         |-> $past(advance && setup_mode_ff))
      else $error("gain changed outside setup mode");

endmodule

### hdl/dsa_enc_channel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsa_enc_channel
// One encoder: A/B history, quadrature decode and button debounce counter.
// ----------------------------------------------------------------------------
module dsa_enc_channel
   import dsa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               prime_en,
   input  logic               update_en,
   input  logic [1:0]         ab,
   input  logic               button,
   input  logic [3:0]         debounce_limit,
   output dsa_enc_status_type status
);

   logic [1:0] prev_ab_ff, prev_ab_in;
   logic [3:0] count_ff, count_in;
   logic       settled_ff, settled_in;
   logic       click;
   dsa_dir_type dir;

   always_comb begin
      prev_ab_in = prev_ab_ff;
      count_in   = count_ff;
      settled_in = settled_ff;
      click      = 1'b0;
      dir        = DIR_NONE;
      if (prime_en) begin
         prev_ab_in = ab;
      end
      if (update_en) begin
         prev_ab_in = ab;
         dir        = dsa_decode(prev_ab_ff, ab);
         if (!button) begin
            // count up toward the limit, then settle pressed once
            if (count_ff < debounce_limit) begin
               count_in = count_ff + 4'd1;
            end else if (!settled_ff) begin
               settled_in = 1'b1;
               click      = 1'b1;
            end
         end else begin
            if (count_ff != 4'd0) begin
               count_in = count_ff - 4'd1;
            end else begin
               settled_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ab_ff <= 2'd0;
         count_ff   <= 4'd0;
         settled_ff <= 1'b0;
      end else begin
         prev_ab_ff <= prev_ab_in;
         count_ff   <= count_in;
         settled_ff <= settled_in;
      end
   end

   assign status.dir     = dir;
   assign status.click   = click;
   assign status.settled = settled_in;

endmodule
